@@ rtl/twcr_pkg.sv @@
// ----------------------------------------------------------------------------
// twcr_pkg
// shared types and constants for the textured wall column renderer
// ----------------------------------------------------------------------------
`default_nettype none
package twcr_pkg;

  localparam int unsigned ScreenHeightDef = 64;
  localparam int unsigned TexSizeDef      = 64;

  localparam logic [1:0] FaceN = 2'd0;
  localparam logic [1:0] FaceS = 2'd1;
  localparam logic [1:0] FaceE = 2'd2;
  localparam logic [1:0] FaceW = 2'd3;

  localparam logic OpLoad = 1'b0;
  localparam logic OpDraw = 1'b1;

  typedef struct packed {
    logic               is_load;
    logic [13:0]        addr;
    logic [31:0]        data;
    logic [9:0]         col_x;
    logic [1:0]         face;
    logic [5:0]         tcol;
    logic [6:0]         y;
    logic [6:0]         top;
    logic signed [39:0] acc;
    logic [22:0]        step;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  x;
    logic [5:0]  y;
    logic [31:0] color;
    logic        last;
  } pix_t;

  typedef enum logic [2:0] {
    F_IDLE, F_DIV1, F_HT, F_DIV2, F_MUL, F_PUSH
  } front_state_e;

  typedef enum logic {
    B_IDLE, B_RUN
  } back_state_e;

endpackage
`default_nettype wire

@@ rtl/twcr_ram.sv @@
// ----------------------------------------------------------------------------
// twcr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module twcr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/twcr_front.sv @@
// ----------------------------------------------------------------------------
// twcr_front
// accepts items, forwards loads, works out height and step of a draw item
// with one shared serial divider, and its texture column with a multiply
// ----------------------------------------------------------------------------
`default_nettype none
module twcr_front #(
  parameter int unsigned SCREEN_HEIGHT = twcr_pkg::ScreenHeightDef,
  parameter int unsigned TEX_SIZE      = twcr_pkg::TexSizeDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire logic          opcode_i,
  input  wire logic [13:0]   texel_index_i,
  input  wire logic [31:0]   texel_rgba_i,
  input  wire logic [9:0]    column_x_i,
  input  wire logic          hit_horizontal_i,
  input  wire logic          step_x_negative_i,
  input  wire logic          step_y_negative_i,
  input  wire logic [23:0]   viewer_x_i,
  input  wire logic [23:0]   viewer_y_i,
  input  wire logic [23:0]   perp_distance_i,
  input  wire logic [23:0]   travel_x_i,
  input  wire logic [23:0]   travel_y_i,
  output logic               cq_push_o,
  output twcr_pkg::cmd_t     cq_data_o,
  input  wire logic          cq_full_i
);
  import twcr_pkg::*;

  localparam logic [22:0]        Num1 = 23'(SCREEN_HEIGHT << 16);
  localparam logic [22:0]        Num2 = 23'(TEX_SIZE << 16);
  localparam logic [16:0]        Half = 17'(SCREEN_HEIGHT / 2);
  localparam logic [16:0]        Sh   = 17'(SCREEN_HEIGHT);
  localparam logic signed [39:0] Acc0 = 40'((TEX_SIZE - 1) << 16);
  localparam logic [7:0]         Ts   = 8'(TEX_SIZE);

  front_state_e state_q, state_d;

  logic [23:0] rem_q, rem_d;
  logic [22:0] quo_q, quo_d;
  logic [23:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] f_q, f_d;
  logic        rev_q, rev_d;
  logic [1:0]  face_q, face_d;
  logic [9:0]  colx_q, colx_d;
  logic [6:0]  y_q, y_d;
  logic [6:0]  top_q, top_d;
  logic [15:0] diff_q, diff_d;
  logic [22:0] step_q, step_d;
  logic [38:0] prod_q, prod_d;
  logic [5:0]  tcol_q, tcol_d;

  logic [24:0] rem_n;
  logic        ge;
  logic [23:0] w;
  logic        accept;
  logic [15:0] h;
  logic [16:0] bottom;
  logic [16:0] fsel;
  logic [23:0] uprod;
  logic [7:0]  u;

  always_comb begin
    rem_n = {rem_q, quo_q[22]};
    ge    = rem_n >= {1'b0, den_q};
  end

  always_comb begin
    if (hit_horizontal_i) begin
      w = step_x_negative_i ? (viewer_x_i - travel_x_i) : (viewer_x_i + travel_x_i);
    end else begin
      w = step_y_negative_i ? (viewer_y_i - travel_y_i) : (viewer_y_i + travel_y_i);
    end
  end

  assign h      = (quo_q[22:16] != 7'd0) ? 16'hFFFF : quo_q[15:0];
  assign bottom = Half + {2'b0, h[15:1]};
  assign fsel   = rev_q ? (17'h10000 - {1'b0, f_q}) : {1'b0, f_q};
  assign uprod  = fsel * {9'b0, Ts};
  assign u      = uprod[23:16];

  assign full_o = !(state_q == F_IDLE && !cq_full_i);
  assign accept = push_i && !full_o;

  always_comb begin
    state_d   = state_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    den_d     = den_q;
    cnt_d     = cnt_q;
    f_d       = f_q;
    rev_d     = rev_q;
    face_d    = face_q;
    colx_d    = colx_q;
    y_d       = y_q;
    top_d     = top_q;
    diff_d    = diff_q;
    step_d    = step_q;
    prod_d    = prod_q;
    tcol_d    = tcol_q;
    cq_push_o = 1'b0;
    cq_data_o = '0;
    case (state_q)
      F_IDLE: begin
        cq_data_o.is_load = 1'b1;
        cq_data_o.addr    = texel_index_i;
        cq_data_o.data    = texel_rgba_i;
        if (accept) begin
          if (opcode_i == OpLoad) begin
            cq_push_o = 1'b1;
          end else begin
            f_d    = w[15:0];
            colx_d = column_x_i;
            if (hit_horizontal_i) begin
              face_d = step_y_negative_i ? FaceN : FaceS;
              rev_d  = !step_y_negative_i;
            end else begin
              face_d = step_x_negative_i ? FaceW : FaceE;
              rev_d  = step_x_negative_i;
            end
            rem_d   = '0;
            quo_d   = Num1;
            den_d   = perp_distance_i;
            cnt_d   = 5'd22;
            state_d = F_DIV1;
          end
        end
      end
      F_DIV1, F_DIV2: begin
        rem_d = ge ? 24'(rem_n - {1'b0, den_q}) : rem_n[23:0];
        quo_d = {quo_q[21:0], ge};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          state_d = (state_q == F_DIV1) ? F_HT : F_MUL;
        end
      end
      F_HT: begin
        if (h == 16'd0) begin
          state_d = F_IDLE;
        end else begin
          if (bottom >= Sh) begin
            y_d    = 7'(SCREEN_HEIGHT - 1);
            top_d  = '0;
            diff_d = 16'(bottom - Sh);
          end else begin
            y_d    = 7'(bottom - 17'd1);
            top_d  = 7'(Half - {2'b0, h[15:1]});
            diff_d = '0;
          end
          rem_d   = '0;
          quo_d   = Num2;
          den_d   = {8'b0, h};
          cnt_d   = 5'd22;
          state_d = F_DIV2;
        end
      end
      F_MUL: begin
        step_d  = quo_q;
        prod_d  = diff_q * quo_q;
        tcol_d  = (u >= Ts) ? 6'd0 : u[5:0];
        state_d = F_PUSH;
      end
      F_PUSH: begin
        cq_data_o.is_load = 1'b0;
        cq_data_o.col_x   = colx_q;
        cq_data_o.face    = face_q;
        cq_data_o.tcol    = tcol_q;
        cq_data_o.y       = y_q;
        cq_data_o.top     = top_q;
        cq_data_o.acc     = Acc0 - $signed({1'b0, prod_q});
        cq_data_o.step    = step_q;
        if (y_q < top_q) begin
          state_d = F_IDLE;
        end else if (!cq_full_i) begin
          cq_push_o = 1'b1;
          state_d   = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    cnt_q  <= cnt_d;
    f_q    <= f_d;
    rev_q  <= rev_d;
    face_q <= face_d;
    colx_q <= colx_d;
    y_q    <= y_d;
    top_q  <= top_d;
    diff_q <= diff_d;
    step_q <= step_d;
    prod_q <= prod_d;
    tcol_q <= tcol_d;
  end

endmodule
`default_nettype wire

@@ rtl/twcr_back.sv @@
// ----------------------------------------------------------------------------
// twcr_back
// carries out loads and walks a draw column, one texel read per pixel,
// into a small result queue
// ----------------------------------------------------------------------------
`default_nettype none
module twcr_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cq_empty_i,
  input  twcr_pkg::cmd_t      cq_data_i,
  output logic                cq_pop_o,
  output logic                empty,
  input  wire logic           pop,
  output logic [9:0]          pixel_x_o,
  output logic [5:0]          pixel_y_o,
  output logic [31:0]         pixel_color_o,
  output logic                last_pixel_o
);
  import twcr_pkg::*;

  localparam int unsigned OqDepth = 4;

  back_state_e state_q, state_d;

  logic [9:0]         colx_q, colx_d;
  logic [1:0]         face_q, face_d;
  logic [5:0]         tcol_q, tcol_d;
  logic [6:0]         y_q, y_d;
  logic [6:0]         top_q, top_d;
  logic signed [39:0] acc_q, acc_d;
  logic [22:0]        step_q, step_d;

  logic        rdv_q, rdv_d;
  logic [9:0]  rdx_q;
  logic [5:0]  rdy_q;
  logic        rdl_q;

  pix_t        oq_q [OqDepth];
  logic [1:0]  owp_q, orp_q;
  logic [2:0]  ocnt_q;

  logic        we;
  logic [13:0] raddr;
  logic [31:0] rdata;
  logic [5:0]  trow;
  logic        issue;
  logic        last;
  logic [3:0]  credit;
  logic        opop;

  twcr_ram #(.Width(32), .Depth(16384)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cq_data_i.addr),
    .wdata_i (cq_data_i.data),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign trow   = (acc_q > 40'sd0) ? acc_q[21:16] : 6'd0;
  assign raddr  = {face_q, trow, tcol_q};
  assign last   = y_q == top_q;
  assign credit = {1'b0, ocnt_q} + {3'b0, rdv_q};
  assign opop   = pop && !empty;

  always_comb begin
    state_d  = state_q;
    colx_d   = colx_q;
    face_d   = face_q;
    tcol_d   = tcol_q;
    y_d      = y_q;
    top_d    = top_q;
    acc_d    = acc_q;
    step_d   = step_q;
    cq_pop_o = 1'b0;
    we       = 1'b0;
    issue    = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!cq_empty_i) begin
          cq_pop_o = 1'b1;
          if (cq_data_i.is_load) begin
            we = 1'b1;
          end else begin
            colx_d  = cq_data_i.col_x;
            face_d  = cq_data_i.face;
            tcol_d  = cq_data_i.tcol;
            y_d     = cq_data_i.y;
            top_d   = cq_data_i.top;
            acc_d   = cq_data_i.acc;
            step_d  = cq_data_i.step;
            state_d = B_RUN;
          end
        end
      end
      B_RUN: begin
        if (credit < 4'(OqDepth)) begin
          issue = 1'b1;
          acc_d = acc_q - $signed({17'b0, step_q});
          y_d   = y_q - 7'd1;
          if (last) begin
            state_d = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign rdv_d = issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      rdv_q   <= 1'b0;
      owp_q   <= '0;
      orp_q   <= '0;
      ocnt_q  <= '0;
    end else begin
      state_q <= state_d;
      rdv_q   <= rdv_d;
      if (rdv_q) begin
        owp_q <= owp_q + 2'd1;
      end
      if (opop) begin
        orp_q <= orp_q + 2'd1;
      end
      ocnt_q <= ocnt_q + {2'b0, rdv_q} - {2'b0, opop};
    end
  end

  always_ff @(posedge clk_i) begin
    colx_q <= colx_d;
    face_q <= face_d;
    tcol_q <= tcol_d;
    y_q    <= y_d;
    top_q  <= top_d;
    acc_q  <= acc_d;
    step_q <= step_d;
    rdx_q  <= colx_q;
    rdy_q  <= y_q[5:0];
    rdl_q  <= last;
    if (rdv_q) begin
      oq_q[owp_q] <= '{x: rdx_q, y: rdy_q, color: rdata, last: rdl_q};
    end
  end

  assign empty         = ocnt_q == 3'd0;
  assign pixel_x_o     = oq_q[orp_q].x;
  assign pixel_y_o     = oq_q[orp_q].y;
  assign pixel_color_o = oq_q[orp_q].color;
  assign last_pixel_o  = oq_q[orp_q].last;

endmodule
`default_nettype wire

@@ rtl/textured_wall_column_renderer.sv @@
// ----------------------------------------------------------------------------
// textured_wall_column_renderer
// texture loads and textured wall column drawing
//
//   channel  handshake     payload
//   in       push / full   opcode, texel_index, texel_rgba, draw fields
//   out      empty / pop   pixel_x, pixel_y, pixel_color, last_pixel
//
// a load passes straight through the front and is written in the back
// a draw holds the front through two 23-step serial divisions
// and emits up to SCREEN_HEIGHT pixels in the back, one texel read each
// front and back overlap through a two-entry command queue
// reset clears control only; texels read undefined until loaded
// a stalled pop holds the back once its four-entry result queue fills
// ----------------------------------------------------------------------------
`default_nettype none
module textured_wall_column_renderer #(
  parameter int unsigned SCREEN_HEIGHT = twcr_pkg::ScreenHeightDef,
  parameter int unsigned TEX_SIZE      = twcr_pkg::TexSizeDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        opcode_i,
  input  wire logic [13:0] texel_index_i,
  input  wire logic [31:0] texel_rgba_i,
  input  wire logic [9:0]  column_x_i,
  input  wire logic        hit_horizontal_i,
  input  wire logic        step_x_negative_i,
  input  wire logic        step_y_negative_i,
  input  wire logic [23:0] viewer_x_i,
  input  wire logic [23:0] viewer_y_i,
  input  wire logic [23:0] perp_distance_i,
  input  wire logic [23:0] travel_x_i,
  input  wire logic [23:0] travel_y_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [9:0]       pixel_x_o,
  output logic [5:0]       pixel_y_o,
  output logic [31:0]      pixel_color_o,
  output logic             last_pixel_o
);
  import twcr_pkg::*;

  cmd_t       cq_q [2];
  logic       cq_wp_q, cq_rp_q;
  logic [1:0] cq_cnt_q;
  logic       cq_push, cq_pop, cq_full, cq_empty;
  cmd_t       cq_wdata;

  assign cq_full  = cq_cnt_q == 2'd2;
  assign cq_empty = cq_cnt_q == 2'd0;

  twcr_front #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TEX_SIZE      (TEX_SIZE)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_o            (full),
    .opcode_i          (opcode_i),
    .texel_index_i     (texel_index_i),
    .texel_rgba_i      (texel_rgba_i),
    .column_x_i        (column_x_i),
    .hit_horizontal_i  (hit_horizontal_i),
    .step_x_negative_i (step_x_negative_i),
    .step_y_negative_i (step_y_negative_i),
    .viewer_x_i        (viewer_x_i),
    .viewer_y_i        (viewer_y_i),
    .perp_distance_i   (perp_distance_i),
    .travel_x_i        (travel_x_i),
    .travel_y_i        (travel_y_i),
    .cq_push_o         (cq_push),
    .cq_data_o         (cq_wdata),
    .cq_full_i         (cq_full)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cq_wp_q  <= 1'b0;
      cq_rp_q  <= 1'b0;
      cq_cnt_q <= '0;
    end else begin
      if (cq_push) begin
        cq_wp_q <= !cq_wp_q;
      end
      if (cq_pop) begin
        cq_rp_q <= !cq_rp_q;
      end
      cq_cnt_q <= cq_cnt_q + {1'b0, cq_push} - {1'b0, cq_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cq_push) begin
      cq_q[cq_wp_q] <= cq_wdata;
    end
  end

  twcr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cq_empty_i    (cq_empty),
    .cq_data_i     (cq_q[cq_rp_q]),
    .cq_pop_o      (cq_pop),
    .empty         (empty),
    .pop           (pop),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// textured wall column renderer testbench
// loads texels and draws wall columns through the push/full port, predicts
// every pixel from its own copy of the texture store and compares each
// popped pixel beat, field by field, with the oldest predicted pixel.
// texels are always loaded before a draw can read them. both sides idle in
// random bursts, and the reader holds off long enough to fill the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import twcr_pkg::*;

  localparam int unsigned ScrH = ScreenHeightDef;
  localparam int unsigned TexN = TexSizeDef;
  localparam int unsigned CycleLimit = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        opcode_i;
  logic [13:0] texel_index_i;
  logic [31:0] texel_rgba_i;
  logic [9:0]  column_x_i;
  logic        hit_horizontal_i;
  logic        step_x_negative_i;
  logic        step_y_negative_i;
  logic [23:0] viewer_x_i;
  logic [23:0] viewer_y_i;
  logic [23:0] perp_distance_i;
  logic [23:0] travel_x_i;
  logic [23:0] travel_y_i;
  logic        empty;
  logic        pop;
  logic [9:0]  pixel_x_o;
  logic [5:0]  pixel_y_o;
  logic [31:0] pixel_color_o;
  logic        last_pixel_o;

  logic [31:0] texel_model [16384];
  bit          texel_loaded [16384];
  pix_t        pending_pixels [$];
  int unsigned error_count;
  int unsigned cycle_count;
  bit          quiet;
  bit          hold_req;

  textured_wall_column_renderer dut (
    .clk_i, .rst_ni, .push, .full, .opcode_i, .texel_index_i, .texel_rgba_i,
    .column_x_i, .hit_horizontal_i, .step_x_negative_i, .step_y_negative_i,
    .viewer_x_i, .viewer_y_i, .perp_distance_i, .travel_x_i, .travel_y_i,
    .empty, .pop, .pixel_x_o, .pixel_y_o, .pixel_color_o, .last_pixel_o
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", msg);
  endtask

  // pixel checker
  always @(posedge clk_i) begin
    pix_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        note_error($sformatf("unexpected pixel x=%0d y=%0d", pixel_x_o, pixel_y_o));
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_x_o !== want.x || pixel_y_o !== want.y ||
            pixel_color_o !== want.color || last_pixel_o !== want.last)
          note_error($sformatf("exp x=%0d y=%0d c=%h l=%0b got x=%0d y=%0d c=%h l=%0b",
                               want.x, want.y, want.color, want.last,
                               pixel_x_o, pixel_y_o, pixel_color_o, last_pixel_o));
      end
    end
  end

  // pixel reader with random stalls and one long hold
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(0, 9)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_beat(input logic op, input logic [13:0] idx, input logic [31:0] rgba,
                           input logic [9:0] colx, input logic hh, input logic sxn,
                           input logic syn, input logic [23:0] vx, input logic [23:0] vy,
                           input logic [23:0] perp_dist, input logic [23:0] tx,
                           input logic [23:0] ty);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    push              <= 1'b1;
    opcode_i          <= op;
    texel_index_i     <= idx;
    texel_rgba_i      <= rgba;
    column_x_i        <= colx;
    hit_horizontal_i  <= hh;
    step_x_negative_i <= sxn;
    step_y_negative_i <= syn;
    viewer_x_i        <= vx;
    viewer_y_i        <= vy;
    perp_distance_i   <= perp_dist;
    travel_x_i        <= tx;
    travel_y_i        <= ty;
    do @(posedge clk_i); while (full);
  endtask

  task automatic load_texel(input logic [13:0] idx, input logic [31:0] rgba);
    texel_model[idx] = rgba;
    texel_loaded[idx] = 1'b1;
    send_beat(OpLoad, idx, rgba, 10'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
              24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
  endtask

  task automatic render_column(input logic [9:0] colx, input logic hh, input logic sxn,
                               input logic syn, input logic [23:0] vx, input logic [23:0] vy,
                               input logic [23:0] perp_dist, input logic [23:0] tx,
                               input logic [23:0] ty);
    longint unsigned hgt, frac, u, stp;
    longint acc;
    int top, bottom, row, n;
    logic [23:0] hit;
    logic [1:0] face;
    logic [5:0] tcol, trow;
    bit rev;
    logic [13:0] addr [$];
    pix_t pix [$];
    pix_t p;
    if (perp_dist == 0) hgt = 65535;
    else begin
      hgt = (longint'(ScrH) << 16) / perp_dist;
      if (hgt > 65535) hgt = 65535;
    end
    if (hgt != 0) begin
      if (hh) begin
        hit  = sxn ? vx - tx : vx + tx;
        face = syn ? FaceN : FaceS;
        rev  = !syn;
      end else begin
        hit  = syn ? vy - ty : vy + ty;
        face = sxn ? FaceW : FaceE;
        rev  = sxn;
      end
      frac = hit[15:0];
      u = rev ? (((65536 - frac) * TexN) >> 16) : ((frac * TexN) >> 16);
      tcol = 6'(u % TexN);
      stp = (longint'(TexN) << 16) / hgt;
      top = int'(ScrH / 2) - int'(hgt / 2);
      bottom = int'(ScrH / 2) + int'(hgt / 2);
      if (bottom < int'(ScrH)) begin
        row = bottom - 1;
        acc = longint'(TexN - 1) * 65536;
      end else begin
        row = ScrH - 1;
        acc = longint'(TexN - 1) * 65536 - longint'(bottom - int'(ScrH)) * longint'(stp);
        top = 0;
      end
      n = 0;
      while (row >= top && n < int'(ScrH)) begin
        trow = (acc > 0) ? 6'((acc >> 16) % TexN) : 6'd0;
        addr.push_back({face, trow, tcol});
        p.x = colx;
        p.y = row[5:0];
        p.last = 1'b0;
        pix.push_back(p);
        n++;
        acc -= longint'(stp);
        row--;
      end
    end
    foreach (addr[i])
      if (!texel_loaded[addr[i]]) load_texel(addr[i], $urandom);
    foreach (pix[i]) begin
      pix[i].color = texel_model[addr[i]];
      pix[i].last = (i == pix.size() - 1);
      pending_pixels.push_back(pix[i]);
    end
    send_beat(OpDraw, 14'($urandom), $urandom, colx, hh, sxn, syn, vx, vy, perp_dist,
              tx, ty);
  endtask

  task automatic random_draw();
    logic [23:0] perp_dist;
    logic [9:0]  colx;
    logic        hh, sxn, syn;
    logic [23:0] vx, vy, tx, ty;
    logic [15:0] frac_want;
    colx = 10'($urandom);
    hh   = 1'($urandom);
    sxn  = 1'($urandom);
    syn  = 1'($urandom);
    vx   = 24'($urandom);
    vy   = 24'($urandom);
    tx   = 24'($urandom);
    ty   = 24'($urandom);
    // small hit fraction so draws share texture columns 0 and 63
    frac_want = 16'($urandom_range(0, 1023));
    if (hh) tx[15:0] = sxn ? vx[15:0] - frac_want : frac_want - vx[15:0];
    else ty[15:0] = syn ? vy[15:0] - frac_want : frac_want - vy[15:0];
    case ($urandom_range(0, 9))
      0: perp_dist = 24'($urandom);
      1: perp_dist = 24'($urandom_range(0, 24'h00ffff));
      default: perp_dist = 24'($urandom_range(24'h004000, 24'h080000));
    endcase
    render_column(colx, hh, sxn, syn, vx, vy, perp_dist, tx, ty);
  endtask

  task automatic test_directed();
    load_texel(14'h0000, 32'h0000_0000);
    load_texel(14'h3fff, 32'hffff_ffff);
    render_column(10'd0,    1'b1, 1'b0, 1'b0, 24'h0, 24'h0, 24'h010000, 24'h0, 24'h0);
    render_column(10'd1023, 1'b1, 1'b0, 1'b1, 24'hffffff, 24'h0, 24'h000001,
                  24'hffffff, 24'h0);
    render_column(10'd5,    1'b0, 1'b0, 1'b0, 24'h0, 24'h012345, 24'h000000,
                  24'h0, 24'h004321);
    render_column(10'd6,    1'b0, 1'b1, 1'b0, 24'h0, 24'h000100, 24'h00ffff,
                  24'h0, 24'h800000);
    render_column(10'd7,    1'b0, 1'b1, 1'b1, 24'h0, 24'h000100, 24'h020000,
                  24'h0, 24'h020000);
    render_column(10'd8,    1'b1, 1'b1, 1'b0, 24'h000005, 24'h0, 24'h008000,
                  24'h030000, 24'h0);
    render_column(10'd9,    1'b0, 1'b1, 1'b0, 24'h0, 24'h030000, 24'h040000,
                  24'h0, 24'h0);
    render_column(10'd10,   1'b1, 1'b0, 1'b0, 24'h0, 24'h0, 24'hffffff, 24'h0, 24'h0);
    render_column(10'd11,   1'b1, 1'b0, 1'b0, 24'h0, 24'h0, 24'h400000, 24'h0, 24'h0);
    render_column(10'd12,   1'b0, 1'b0, 1'b1, 24'h0, 24'hffffff, 24'h200000,
                  24'h0, 24'hffffff);
    render_column(10'd13,   1'b1, 1'b1, 1'b1, 24'hffffff, 24'hffffff, 24'h010410,
                  24'hffffff, 24'hffffff);
  endtask

  task automatic test_random();
    repeat (35) begin
      if ($urandom_range(0, 4) == 0) load_texel(14'($urandom), $urandom);
      else random_draw();
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (12) random_draw();
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    repeat (20) random_draw();
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    opcode_i = 1'b0;
    texel_index_i = '0;
    texel_rgba_i = '0;
    column_x_i = '0;
    hit_horizontal_i = 1'b0;
    step_x_negative_i = 1'b0;
    step_y_negative_i = 1'b0;
    viewer_x_i = '0;
    viewer_y_i = '0;
    perp_distance_i = '0;
    travel_x_i = '0;
    travel_y_i = '0;
    error_count = 0;
    cycle_count = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    test_quiet_tail();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ textured_wall_column_renderer.f @@
rtl/twcr_pkg.sv
rtl/twcr_ram.sv
rtl/twcr_front.sv
rtl/twcr_back.sv
rtl/textured_wall_column_renderer.sv
tb/sv/testbench.sv
